@@ rtl/rfve_pkg.sv @@
// shared types and constants of the variable-element ring fifo
// no dependencies
package rfve_pkg;

  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int VALUE_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int BYTES_W    = 11;
  localparam int ELEM_W     = 3;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_GET   = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADCFG = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_BYTES = 2'd1;

  localparam logic [BYTES_W-1:0] BYTES_RST = 11'd1024;
  localparam logic [ELEM_W-1:0]  ELEM_RST  = 3'd1;

  typedef struct packed {
    logic              bad;
    logic              clear;
    logic [ELEM_W-1:0] elem_bytes;
  } cfg_stat_t;

endpackage

@@ rtl/rfve_cfg.sv @@
// configuration registers and geometry check of the ring fifo
// depends on rfve_pkg
module rfve_cfg #(
  parameter int STORE_BYTES       = 1024,
  parameter int MAX_ELEMENT_BYTES = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic [rfve_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [rfve_pkg::CFG_DATA_W-1:0] wr_data_i,
  output rfve_pkg::cfg_stat_t             stat_o,
  output logic [$clog2(STORE_BYTES):0]    bytes_eff_o
);
  import rfve_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  localparam int BW = (AW + 1 > BYTES_W) ? AW + 1 : BYTES_W;
  localparam int SW = AW + 2;

  logic [BYTES_W-1:0] bytes_q, bytes_d;
  logic [ELEM_W-1:0]  elem_q, elem_d;
  logic [BW-1:0]      bytes_ext;
  logic [SW-1:0]      two_elem;

  always_comb begin
    bytes_d = bytes_q;
    elem_d  = elem_q;
    if (wr_en_i && wr_index_i == REG_BUFFER_BYTES) begin
      bytes_d = wr_data_i[BYTES_W-1:0];
    end
    if (wr_en_i && wr_index_i == REG_ELEMENT_BYTES) begin
      elem_d = wr_data_i[ELEM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q <= BYTES_RST;
      elem_q  <= ELEM_RST;
    end else begin
      bytes_q <= bytes_d;
      elem_q  <= elem_d;
    end
  end

  // oversized store clamps to the physical size
  assign bytes_ext   = BW'(bytes_q);
  assign bytes_eff_o = (bytes_ext > BW'(STORE_BYTES)) ? (AW + 1)'(STORE_BYTES)
                                                      : (AW + 1)'(bytes_ext);
  assign two_elem    = SW'(elem_q) << 1;

  assign stat_o.elem_bytes = elem_q;
  assign stat_o.bad        = (elem_q == '0) || (32'(elem_q) > 32'(MAX_ELEMENT_BYTES))
                             || (two_elem > SW'(bytes_eff_o));
  assign stat_o.clear      = wr_en_i && (wr_index_i == REG_BUFFER_BYTES ||
                                         wr_index_i == REG_ELEMENT_BYTES);

endmodule

@@ rtl/ring_fifo_variable_element.sv @@
// ring fifo of variable-size elements over a byte-wide synchronous store
// depends on rfve_pkg and rfve_cfg
//
// Usage: a request is taken when start is high and busy is low. operation_i
// selects put, get or flush; put_value_i carries the element for a put.
// Every request yields one result, shown for one cycle with done_o high:
// status_o, get_value_o and now_empty_o. The receiver cannot stall, so a
// result is always taken in the cycle it appears.
// Timing: flush, no-op and refused requests (bad configuration, full, empty)
// answer in the cycle after acceptance and keep busy low. A put writes one
// byte per cycle through the single store port, busy meanwhile, and answers
// after its last byte is written. A get reads one byte per cycle through the
// registered store read and answers after its last byte has returned. Control
// requests can thus be taken one per cycle, while a put or get holds busy
// high until its result, as every byte passes the one byte-wide store port.
// Configuration writes on the cfg channel are taken while busy is low; a
// write to buffer_bytes or element_bytes empties the queue. Reset empties the
// queue and loads buffer_bytes 1024 and element_bytes 1; store contents are
// undefined until written.
module ring_fifo_variable_element #(
  parameter int STORE_BYTES       = 1024,
  parameter int MAX_ELEMENT_BYTES = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [rfve_pkg::OP_W-1:0]       operation_i,
  input  logic [rfve_pkg::VALUE_W-1:0]    put_value_i,
  output logic                            done_o,
  output logic [rfve_pkg::STATUS_W-1:0]   status_o,
  output logic [rfve_pkg::VALUE_W-1:0]    get_value_o,
  output logic                            now_empty_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rfve_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rfve_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rfve_pkg::*;

  localparam int AW    = $clog2(STORE_BYTES);
  localparam int SW    = AW + 2;
  localparam int IW    = (MAX_ELEMENT_BYTES > 1) ? $clog2(MAX_ELEMENT_BYTES) : 1;
  localparam int ACC_W = 8 * MAX_ELEMENT_BYTES;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PUT  = 2'd1;
  localparam logic [1:0] S_GET  = 2'd2;

  cfg_stat_t      cfg;
  logic [AW:0]    bytes_eff;

  logic [1:0]     state_q, state_d;
  logic [AW-1:0]  head_q, head_d, tail_q, tail_d, next_q, next_d;
  logic [IW-1:0]  cnt_q, cnt_d, rbyte_q, rbyte_d;
  logic           iss_done_q, iss_done_d, rvalid_q, rvalid_d;
  logic [ACC_W-1:0] data_q, data_d, acc_m;

  logic                done_q, done_d, empty_q, empty_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [VALUE_W-1:0]  value_q, value_d;

  logic [SW-1:0]  eb_s, lim_s, tail_inc, head_inc;
  logic [AW-1:0]  tail_nxt, head_nxt;
  logic           accept, last_cnt, last_rbyte;

  logic [7:0]     mem [STORE_BYTES];
  logic           mem_we;
  logic [AW-1:0]  waddr, raddr;
  logic [7:0]     wdata, rdata_q;

  rfve_cfg #(
    .STORE_BYTES       (STORE_BYTES),
    .MAX_ELEMENT_BYTES (MAX_ELEMENT_BYTES)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (cfg_valid_i && cfg_ready_o),
    .wr_index_i  (cfg_index_i),
    .wr_data_i   (cfg_data_i),
    .stat_o      (cfg),
    .bytes_eff_o (bytes_eff)
  );

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = !busy;
  assign accept      = start && !busy;

  // slot advance in byte addresses: wrap when the next slot would not fit
  assign eb_s     = SW'(cfg.elem_bytes);
  assign lim_s    = SW'(bytes_eff);
  assign tail_inc = SW'(tail_q) + eb_s;
  assign head_inc = SW'(head_q) + eb_s;
  assign tail_nxt = (tail_inc + eb_s > lim_s) ? '0 : AW'(tail_inc);
  assign head_nxt = (head_inc + eb_s > lim_s) ? '0 : AW'(head_inc);

  assign last_cnt   = (ELEM_W'(cnt_q) == cfg.elem_bytes - ELEM_W'(1));
  assign last_rbyte = (ELEM_W'(rbyte_q) == cfg.elem_bytes - ELEM_W'(1));

  always_comb begin
    acc_m = data_q;
    acc_m[8*rbyte_q +: 8] = rdata_q;
  end

  assign mem_we = (state_q == S_PUT);
  assign waddr  = AW'(SW'(tail_q) + SW'(cnt_q));
  assign wdata  = data_q[8*cnt_q +: 8];
  assign raddr  = AW'(SW'(head_q) + SW'(cnt_q));

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    next_d     = next_q;
    cnt_d      = cnt_q;
    rbyte_d    = rbyte_q;
    iss_done_d = iss_done_q;
    rvalid_d   = 1'b0;
    data_d     = data_q;
    done_d     = 1'b0;
    status_d   = status_q;
    value_d    = value_q;
    empty_d    = empty_q;
    case (state_q)
      S_IDLE: begin
        if (cfg.clear) begin
          head_d = '0;
          tail_d = '0;
        end
        if (accept) begin
          cnt_d      = '0;
          iss_done_d = 1'b0;
          if (operation_i == OP_FLUSH) begin
            head_d   = '0;
            tail_d   = '0;
            done_d   = 1'b1;
            status_d = ST_OK;
            value_d  = '0;
            empty_d  = 1'b1;
          end else if (operation_i == OP_PUT || operation_i == OP_GET) begin
            if (cfg.bad) begin
              done_d   = 1'b1;
              status_d = ST_BADCFG;
              value_d  = '0;
              empty_d  = (head_q == tail_q);
            end else if (operation_i == OP_PUT) begin
              if (tail_nxt == head_q) begin
                done_d   = 1'b1;
                status_d = ST_FULL;
                value_d  = '0;
                empty_d  = (head_q == tail_q);
              end else begin
                state_d = S_PUT;
                next_d  = tail_nxt;
                data_d  = ACC_W'(put_value_i);
              end
            end else begin
              if (head_q == tail_q) begin
                done_d   = 1'b1;
                status_d = ST_EMPTY;
                value_d  = '0;
                empty_d  = 1'b1;
              end else begin
                state_d = S_GET;
                next_d  = head_nxt;
                data_d  = '0;
              end
            end
          end else begin
            done_d   = 1'b1;
            status_d = ST_OK;
            value_d  = '0;
            empty_d  = (head_q == tail_q);
          end
        end
      end
      S_PUT: begin
        cnt_d = cnt_q + IW'(1);
        if (last_cnt) begin
          tail_d   = next_q;
          state_d  = S_IDLE;
          done_d   = 1'b1;
          status_d = ST_OK;
          value_d  = '0;
          empty_d  = (next_q == head_q);
        end
      end
      S_GET: begin
        if (!iss_done_q) begin
          rvalid_d   = 1'b1;
          rbyte_d    = cnt_q;
          cnt_d      = cnt_q + IW'(1);
          iss_done_d = last_cnt;
        end
        if (rvalid_q) begin
          data_d = acc_m;
          if (last_rbyte) begin
            head_d   = next_q;
            state_d  = S_IDLE;
            done_d   = 1'b1;
            status_d = ST_OK;
            value_d  = VALUE_W'(acc_m);
            empty_d  = (next_q == tail_q);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      cnt_q      <= '0;
      iss_done_q <= 1'b0;
      rvalid_q   <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      cnt_q      <= cnt_d;
      iss_done_q <= iss_done_d;
      rvalid_q   <= rvalid_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    next_q   <= next_d;
    rbyte_q  <= rbyte_d;
    data_q   <= data_d;
    status_q <= status_d;
    value_q  <= value_d;
    empty_q  <= empty_d;
  end

  // byte store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign get_value_o = value_q;
  assign now_empty_o = empty_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == S_IDLE)
    else $error("result shown while a request is still in progress");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> get_value_o == '0)
    else $error("refused request returned data");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_EMPTY |-> now_empty_o)
    else $error("empty get did not report an empty queue");

  a_tail_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg.bad |-> SW'(tail_q) + eb_s <= lim_s)
    else $error("tail slot outside the configured store");

  a_busy_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (operation_i == OP_PUT) && !cfg.bad && (tail_nxt != head_q) |=> busy)
    else $error("accepted put did not start writing");

endmodule
